// ===== rtl/core/rdfp_pkg.sv =====
// Radar distance frame parser: shared types and constants.
// Used by rdfp_framer, rdfp_sample_ring and radar_distance_frame_parser.
`default_nettype none

package rdfp_pkg;

  localparam int unsigned FRAME_LEN       = 8;
  localparam int unsigned CNT_W           = $clog2(FRAME_LEN);
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DIST_W          = 16;
  localparam int unsigned TICK_W          = 32;
  localparam int unsigned CTR_W           = 32;
  localparam int unsigned FILL_W          = 4;

  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] TAIL_BYTE = 8'h00;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2
  } frame_status_e;

  typedef struct packed {
    logic              good;
    logic              bad;
    logic [DIST_W-1:0] distance;
  } frame_evt_t;

  typedef struct packed {
    logic              valid;
    logic [FILL_W-1:0] fill;
    logic [DIST_W-1:0] distance;
    logic [TICK_W-1:0] sample_tick;
  } ring_view_t;

endpackage

`default_nettype wire

// ===== rtl/core/radar_distance_frame_parser.sv =====
// Radar distance frame parser top level: framer, sample ring, counters, result register.
// Depends on rdfp_pkg, rdfp_framer and rdfp_sample_ring.
//
//   channel   valid / ready            payload
//   request   in_valid_i / in_ready_o  rx_byte_i, tick_now_i
//   result    out_valid_o / out_ready_i frame_status_o, latest_*_o, queue_fill_o, counters
//
// One byte per cycle; a result appears the cycle after its request is taken.
// Framer and ring pointers advance in the accepting cycle; the newest sample is read
// from the ring memory into a register, forwarded when written by that same request.
// A held result stalls the request side only when out_ready_i is low.
// Reset clears framer, pointers and counters; the ring memory is not cleared.
`default_nettype none

module radar_distance_frame_parser
  import rdfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [TICK_W-1:0] tick_now_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             frame_status_o,
  output logic                   latest_valid_o,
  output logic [DIST_W-1:0]      latest_distance_o,
  output logic [TICK_W-1:0]      latest_time_o,
  output logic [FILL_W-1:0]      queue_fill_o,
  output logic [CTR_W-1:0]       good_frames_o,
  output logic [CTR_W-1:0]       bad_frames_o,
  output logic [CTR_W-1:0]       overwritten_o
);

  logic          accept;
  frame_evt_t    evt;
  ring_view_t    view;
  logic          drop;
  logic          out_valid_q;
  frame_status_e status_q, status_d;
  logic [CTR_W-1:0] good_q, bad_q, ovf_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  rdfp_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (accept),
    .rx_byte_i (rx_byte_i),
    .evt_o     (evt)
  );

  rdfp_sample_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .push_i      (evt.good),
    .push_dist_i (evt.distance),
    .push_tick_i (tick_now_i),
    .drop_o      (drop),
    .view_o      (view)
  );

  always_comb begin
    priority if (evt.good) begin
      status_d = ST_GOOD;
    end else if (evt.bad) begin
      status_d = ST_BAD;
    end else begin
      status_d = ST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_NONE;
      good_q      <= '0;
      bad_q       <= '0;
      ovf_q       <= '0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        status_q <= status_d;
        if (evt.good) begin
          good_q <= good_q + CTR_W'(1);
        end
        if (evt.bad) begin
          bad_q <= bad_q + CTR_W'(1);
        end
        if (drop) begin
          ovf_q <= ovf_q + CTR_W'(1);
        end
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_status_o    = status_q;
  assign latest_valid_o    = view.valid;
  assign latest_distance_o = view.distance;
  assign latest_time_o     = view.sample_tick;
  assign queue_fill_o      = view.fill;
  assign good_frames_o     = good_q;
  assign bad_frames_o      = bad_q;
  assign overwritten_o     = ovf_q;

`ifndef NO_ASSERTIONS
  a_valid_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    latest_valid_o |=> latest_valid_o)
    else $error("sample queue became empty");

  a_good_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == ST_GOOD) |-> latest_valid_o)
    else $error("good frame reported with empty queue");

  a_good_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && evt.good) |=> (good_frames_o == $past(good_frames_o) + CTR_W'(1)))
    else $error("good frame count did not advance");

  a_drop_when_good : assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop |-> evt.good)
    else $error("ring overwrite without a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rdfp_framer.sv =====
// Byte framer: 8-byte shift buffer that slides until a 0xFF 0xFF 0xFF header aligns.
// Depends on rdfp_pkg.
`default_nettype none

module rdfp_framer
  import rdfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       advance_i,
  input  wire logic [7:0] rx_byte_i,
  output frame_evt_t      evt_o
);

  logic [7:0]       fb_q   [FRAME_LEN];
  logic [7:0]       fb_d   [FRAME_LEN];
  logic [7:0]       wr     [FRAME_LEN];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W:0]   cnt_inc;
  logic             hdr_bad;
  logic             slide;
  logic             frame_end;
  logic             tail_ok;

  always_comb begin
    for (int i = 0; i < FRAME_LEN; i++) begin
      wr[i] = (cnt_q == CNT_W'(i)) ? rx_byte_i : fb_q[i];
    end
    cnt_inc   = {1'b0, cnt_q} + (CNT_W+1)'(1);
    hdr_bad   = (wr[0] != HDR_BYTE) || (wr[1] != HDR_BYTE) || (wr[2] != HDR_BYTE);
    slide     = (cnt_inc >= (CNT_W+1)'(3)) && hdr_bad;
    frame_end = !slide && (cnt_inc == (CNT_W+1)'(FRAME_LEN));
    tail_ok   = (wr[5] == TAIL_BYTE) && (wr[6] == TAIL_BYTE) && (wr[7] == TAIL_BYTE);

    for (int i = 0; i < FRAME_LEN; i++) begin
      fb_d[i] = wr[i];
    end
    if (slide) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        fb_d[i] = wr[i+1];
      end
      cnt_d = cnt_q;
    end else if (frame_end) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_inc[CNT_W-1:0];
    end

    evt_o.good     = frame_end && tail_ok;
    evt_o.bad      = frame_end && !tail_ok;
    evt_o.distance = {wr[3], wr[4]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < FRAME_LEN; i++) begin
        fb_q[i] <= '0;
      end
    end else if (advance_i) begin
      cnt_q <= cnt_d;
      for (int i = 0; i < FRAME_LEN; i++) begin
        fb_q[i] <= fb_d[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rdfp_sample_ring.sv =====
// Sample ring: overwriting ring queue of distance/tick samples in one synchronous memory.
// Newest entry read back each request, forwarded when written the same cycle. Uses rdfp_pkg.
`default_nettype none

module rdfp_sample_ring
  import rdfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic              push_i,
  input  wire logic [DIST_W-1:0] push_dist_i,
  input  wire logic [TICK_W-1:0] push_tick_i,
  output logic                   drop_o,
  output ring_view_t             view_o
);

  localparam int unsigned PW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned WORD_W = DIST_W + TICK_W;
  localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);

  logic [WORD_W-1:0] mem [QUEUE_DEPTH];

  logic [PW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [PW-1:0]     wp_nxt, rp_nxt, rd_addr;
  logic [PW:0]       fill_w;
  logic [31:0]       fill_ext;
  logic              full;
  logic              valid_q;
  logic [FILL_W-1:0] fill_q;
  logic              fwd_q;
  logic [WORD_W-1:0] fwd_data_q;
  logic [WORD_W-1:0] rd_data_q;
  logic [WORD_W-1:0] newest;

  always_comb begin
    wp_nxt = (wp_q == LAST_IDX) ? '0 : wp_q + PW'(1);
    rp_nxt = (rp_q == LAST_IDX) ? '0 : rp_q + PW'(1);
    full   = (wp_nxt == rp_q);
    drop_o = push_i && full;
    wp_d   = push_i ? wp_nxt : wp_q;
    rp_d   = drop_o ? rp_nxt : rp_q;
    rd_addr = (wp_q == '0) ? LAST_IDX : wp_q - PW'(1);
    if (wp_d >= rp_d) begin
      fill_w = {1'b0, wp_d} - {1'b0, rp_d};
    end else begin
      fill_w = {1'b0, wp_d} + (PW+1)'(QUEUE_DEPTH) - {1'b0, rp_d};
    end
    fill_ext = 32'(fill_w);
  end

  always_ff @(posedge clk_i) begin
    if (load_i && push_i) begin
      mem[wp_q] <= {push_dist_i, push_tick_i};
    end
    if (load_i && !push_i) begin
      rd_data_q <= mem[rd_addr];
    end
    if (load_i) begin
      fwd_data_q <= {push_dist_i, push_tick_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      valid_q <= 1'b0;
      fill_q  <= '0;
      fwd_q   <= 1'b0;
    end else if (load_i) begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      valid_q <= (wp_d != rp_d);
      fill_q  <= fill_ext[FILL_W-1:0];
      fwd_q   <= push_i;
    end
  end

  assign newest             = fwd_q ? fwd_data_q : rd_data_q;
  assign view_o.valid       = valid_q;
  assign view_o.fill        = fill_q;
  assign view_o.distance    = valid_q ? newest[WORD_W-1:TICK_W] : '0;
  assign view_o.sample_tick = valid_q ? newest[TICK_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== sim/tb_radar_distance_frame_parser.sv =====
// Testbench for radar_distance_frame_parser: byte stream stimulus, shadow parser, result check.
// Depends on rdfp_pkg and the radar_distance_frame_parser RTL.
`timescale 1ns / 1ps

typedef struct packed {
  rdfp_pkg::frame_status_e status;
  logic                    valid;
  logic [15:0]             distance;
  logic [31:0]             tick;
  logic [3:0]              fill;
  logic [31:0]             good;
  logic [31:0]             bad;
  logic [31:0]             lost;
} frame_report_t;

class parser_shadow;
  logic [7:0]    frame_buf [8];
  int unsigned   held;
  logic [15:0]   ring_dist [rdfp_pkg::DEF_QUEUE_DEPTH];
  logic [31:0]   ring_tick [rdfp_pkg::DEF_QUEUE_DEPTH];
  int unsigned   wr_ptr;
  int unsigned   rd_ptr;
  logic [31:0]   good_cnt;
  logic [31:0]   bad_cnt;
  logic [31:0]   lost_cnt;
  frame_report_t due_reports[$];
  int unsigned   mismatches;

  function new();
    foreach (frame_buf[i]) frame_buf[i] = '0;
    held       = 0;
    wr_ptr     = 0;
    rd_ptr     = 0;
    good_cnt   = '0;
    bad_cnt    = '0;
    lost_cnt   = '0;
    mismatches = 0;
  endfunction

  // Shadow of the framer and sample ring for one accepted request
  function void take_byte(logic [7:0] b, logic [31:0] t);
    int unsigned   depth = rdfp_pkg::DEF_QUEUE_DEPTH;
    int unsigned   nxt;
    int unsigned   last;
    frame_report_t r;
    r = '0;
    r.status = rdfp_pkg::ST_NONE;
    if (held >= 8) held = 0;
    frame_buf[held % 8] = b;
    held++;
    if (held >= 3 && !(frame_buf[0] == rdfp_pkg::HDR_BYTE && frame_buf[1] == rdfp_pkg::HDR_BYTE &&
                       frame_buf[2] == rdfp_pkg::HDR_BYTE)) begin
      held--;
      for (int i = 0; i < held; i++) frame_buf[i] = frame_buf[i+1];
    end else if (held == 8) begin
      held = 0;
      if (frame_buf[5] != rdfp_pkg::TAIL_BYTE || frame_buf[6] != rdfp_pkg::TAIL_BYTE ||
          frame_buf[7] != rdfp_pkg::TAIL_BYTE) begin
        bad_cnt++;
        r.status = rdfp_pkg::ST_BAD;
      end else begin
        ring_dist[wr_ptr] = {frame_buf[3], frame_buf[4]};
        ring_tick[wr_ptr] = t;
        nxt = (wr_ptr + 1) % depth;
        if (nxt == rd_ptr) begin
          rd_ptr = (rd_ptr + 1) % depth;
          lost_cnt++;
        end
        wr_ptr = nxt;
        good_cnt++;
        r.status = rdfp_pkg::ST_GOOD;
      end
    end
    r.valid = (wr_ptr != rd_ptr);
    if (r.valid) begin
      last = (wr_ptr + depth - 1) % depth;
      r.distance = ring_dist[last];
      r.tick     = ring_tick[last];
    end
    r.fill = 4'((wr_ptr + depth - rd_ptr) % depth);
    r.good = good_cnt;
    r.bad  = bad_cnt;
    r.lost = lost_cnt;
    due_reports.push_back(r);
  endfunction

  function void compare(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  function void match_report(frame_report_t got);
    frame_report_t want;
    if (due_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with no request outstanding");
      return;
    end
    want = due_reports.pop_front();
    compare("frame_status", 32'(want.status), 32'(got.status));
    compare("latest_valid", 32'(want.valid), 32'(got.valid));
    compare("latest_distance", 32'(want.distance), 32'(got.distance));
    compare("latest_time", want.tick, got.tick);
    compare("queue_fill", 32'(want.fill), 32'(got.fill));
    compare("good_frames", want.good, got.good);
    compare("bad_frames", want.bad, got.bad);
    compare("overwritten", want.lost, got.lost);
  endfunction

  function int unsigned pending();
    return due_reports.size();
  endfunction

  function int unsigned failures();
    return mismatches + due_reports.size();
  endfunction
endclass

module tb_radar_distance_frame_parser;
  import rdfp_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = '0;
  logic [31:0] tick_now_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  frame_status_o;
  logic        latest_valid_o;
  logic [15:0] latest_distance_o;
  logic [31:0] latest_time_o;
  logic [3:0]  queue_fill_o;
  logic [31:0] good_frames_o;
  logic [31:0] bad_frames_o;
  logic [31:0] overwritten_o;

  parser_shadow sb = new();
  bit           idle_on = 1'b1;
  int unsigned  sent = 0;

  radar_distance_frame_parser dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .tick_now_i        (tick_now_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_status_o    (frame_status_o),
    .latest_valid_o    (latest_valid_o),
    .latest_distance_o (latest_distance_o),
    .latest_time_o     (latest_time_o),
    .queue_fill_o      (queue_fill_o),
    .good_frames_o     (good_frames_o),
    .bad_frames_o      (bad_frames_o),
    .overwritten_o     (overwritten_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= idle_on ? ($urandom_range(0, 99) >= 37) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_byte(rx_byte_i, tick_now_i);
      if (out_valid_o && out_ready_i) begin
        sb.match_report('{status:   frame_status_e'(frame_status_o),
                          valid:    latest_valid_o,
                          distance: latest_distance_o,
                          tick:     latest_time_o,
                          fill:     queue_fill_o,
                          good:     good_frames_o,
                          bad:      bad_frames_o,
                          lost:     overwritten_o});
      end
    end
  end

  function automatic logic [31:0] next_tick();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(input logic [7:0] b, input logic [31:0] t);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 37) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    tick_now_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_req(seq[i], next_tick());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Mostly frames with random content, some with a corrupted tail, the rest noise and cut-off frames
  task automatic send_random_chunk();
    logic [7:0]  seq[$];
    logic [15:0] range_cm;
    logic [7:0]  tail[3];
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      if ($urandom_range(0, 4) == 0) seq.push_back(HDR_BYTE);
      repeat (3) seq.push_back(HDR_BYTE);
      case ($urandom_range(0, 9))
        0:       range_cm = '0;
        1:       range_cm = '1;
        default: range_cm = 16'($urandom);
      endcase
      seq.push_back(range_cm[15:8]);
      seq.push_back(range_cm[7:0]);
      foreach (tail[i]) tail[i] = TAIL_BYTE;
      if ($urandom_range(0, 4) == 0) begin
        foreach (tail[i]) if ($urandom_range(0, 1)) tail[i] = 8'($urandom);
        if (tail[0] == TAIL_BYTE && tail[1] == TAIL_BYTE && tail[2] == TAIL_BYTE)
          tail[$urandom_range(0, 2)] = 8'($urandom_range(1, 255));
      end
      foreach (tail[i]) seq.push_back(tail[i]);
    end else if (kind < 85) begin
      n = $urandom_range(1, 6);
      repeat (n) seq.push_back(($urandom_range(0, 2) == 0) ? HDR_BYTE : 8'($urandom));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) seq.push_back(HDR_BYTE);
      n = $urandom_range(1, 4);
      repeat (n) seq.push_back(8'($urandom));
    end
    send_bytes(seq);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // noise on an empty queue, a broken header, then a good and a bad frame
    send_req(8'h00, '0);
    send_req(HDR_BYTE, '1);
    send_req(HDR_BYTE, 32'h0000_0001);
    send_req(8'h00, 32'h8000_0000);
    send_bytes('{HDR_BYTE, HDR_BYTE, HDR_BYTE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
    send_bytes('{HDR_BYTE, HDR_BYTE, HDR_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});

    while (sent < 1950) begin
      idle_on = !(sent >= 700 && sent < 1000);
      if (!paused && sent >= 1300) begin
        drain();
        paused = 1'b1;
      end
      send_random_chunk();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.failures() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
